/* design/lsss_pkg.sv */
// lsss_pkg: shared types, codes and constants for the link session supervisor
// no dependencies; imported by link_session_state_supervisor

package lsss_pkg;

  localparam int LIMIT_WIDTH_DEFAULT = 16;
  localparam int CONNECTING_LIMIT_RESET = 5000;
  localparam int REGISTERING_LIMIT_RESET = 5000;
  localparam int STREAMING_LIMIT_RESET = 10000;
  localparam int CFG_INDEX_WIDTH = 4;

  typedef enum logic [2:0] {
    ST_DISCONNECTED = 3'd0,
    ST_CONNECTING   = 3'd1,
    ST_CONNECTED    = 3'd2,
    ST_REGISTERING  = 3'd3,
    ST_STREAMING    = 3'd4,
    ST_ERROR        = 3'd5
  } session_e;

  typedef enum logic [2:0] {
    KIND_REQUEST = 3'd0,
    KIND_TICK    = 3'd1,
    KIND_START   = 3'd2,
    KIND_STOP    = 3'd3,
    KIND_RESET   = 3'd4
  } kind_e;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CONNECTING_LIMIT  = CFG_INDEX_WIDTH'(0);
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_REGISTERING_LIMIT = CFG_INDEX_WIDTH'(1);
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STREAMING_LIMIT   = CFG_INDEX_WIDTH'(2);

  typedef struct packed {
    logic       accepted;
    logic       invalid_request;
    logic       not_running_reject;
    logic [2:0] state_now;
    logic [2:0] state_before;
    logic       changed;
    logic       entered_pulse;
    logic       timed_out;
    logic [2:0] timeout_state;
    logic       running_now;
  } result_t;

  // legal transition table; a request for the current state is always legal
  function automatic logic is_legal(input logic [2:0] from, input logic [2:0] to);
    logic ok;
    ok = 1'b0;
    if (from == to) begin
      ok = 1'b1;
    end else begin
      case (from)
        ST_DISCONNECTED: ok = (to == ST_CONNECTING);
        ST_CONNECTING:   ok = (to == ST_CONNECTED) || (to == ST_DISCONNECTED) ||
                              (to == ST_ERROR);
        ST_CONNECTED:    ok = (to == ST_REGISTERING) || (to == ST_DISCONNECTED) ||
                              (to == ST_ERROR);
        ST_REGISTERING:  ok = (to == ST_STREAMING) || (to == ST_CONNECTED) ||
                              (to == ST_DISCONNECTED) || (to == ST_ERROR);
        ST_STREAMING:    ok = (to == ST_CONNECTED) || (to == ST_DISCONNECTED) ||
                              (to == ST_ERROR);
        ST_ERROR:        ok = (to == ST_DISCONNECTED);
        default:         ok = 1'b0;
      endcase
    end
    return ok;
  endfunction

endpackage

/* design/link_session_state_supervisor.sv */
// link_session_state_supervisor: session state machine with per-state watchdog
// depends on lsss_pkg for state and kind codes, the transition table and result_t
//
// usage:
//   input channel (in_valid_i / in_stall_o) carries one event beat: kind_i and
//   target_state_i. every event produces exactly one result beat on the output
//   channel (out_valid_o / out_stall_i) with the flags and states of that event.
//   the config channel (cfg_valid_i / cfg_ready_o) writes the watchdog limits of
//   Connecting, Registering and Streaming by index 0, 1, 2; it is always ready.
//   throughput: one event per cycle while in_stall_o is low; the state update
//   and watchdog compare sit between the event and the result register, with
//   one add and one compare.
//   a skid register behind the result register keeps the input side taking
//   events while a result waits; in_stall_o rises only once both are full,
//   and it comes from a register, not from out_stall_i.
//   reset: state Disconnected, stopped, watchdog idle, limits 5000/5000/10000,
//   both result registers empty.

module link_session_state_supervisor
  import lsss_pkg::*;
#(
  parameter int LIMIT_WIDTH = LIMIT_WIDTH_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 kind_i,
  input  logic [2:0]                 target_state_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       accepted_o,
  output logic                       invalid_request_o,
  output logic                       not_running_reject_o,
  output logic [2:0]                 state_now_o,
  output logic [2:0]                 state_before_o,
  output logic                       changed_o,
  output logic                       entered_pulse_o,
  output logic                       timed_out_o,
  output logic [2:0]                 timeout_state_o,
  output logic                       running_now_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index_i,
  input  logic [LIMIT_WIDTH-1:0]     cfg_data_i
);

  localparam logic [LIMIT_WIDTH-1:0] ConnRst = LIMIT_WIDTH'(CONNECTING_LIMIT_RESET);
  localparam logic [LIMIT_WIDTH-1:0] RegRst = LIMIT_WIDTH'(REGISTERING_LIMIT_RESET);
  localparam logic [LIMIT_WIDTH-1:0] StrmRst = LIMIT_WIDTH'(STREAMING_LIMIT_RESET);

  logic [LIMIT_WIDTH-1:0] conn_limit_q, reg_limit_q, strm_limit_q;
  logic [2:0]             state_q, state_d;
  logic                   running_q, running_d;
  logic                   armed_q, armed_d;
  logic [LIMIT_WIDTH-1:0] elapsed_q, elapsed_d;

  result_t res;
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;
  logic    in_fire, out_fire, cfg_fire;

  assign in_stall_o  = skid_valid_q;
  assign in_fire     = in_valid_i && !skid_valid_q;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;

  function automatic logic [LIMIT_WIDTH-1:0] limit_of(
    input logic [2:0]             st,
    input logic [LIMIT_WIDTH-1:0] conn,
    input logic [LIMIT_WIDTH-1:0] regs,
    input logic [LIMIT_WIDTH-1:0] strm
  );
    logic [LIMIT_WIDTH-1:0] lim;
    case (st)
      ST_CONNECTING:  lim = conn;
      ST_REGISTERING: lim = regs;
      ST_STREAMING:   lim = strm;
      default:        lim = '0;
    endcase
    return lim;
  endfunction

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conn_limit_q <= ConnRst;
      reg_limit_q  <= RegRst;
      strm_limit_q <= StrmRst;
    end else if (cfg_fire) begin
      case (cfg_index_i)
        CFG_CONNECTING_LIMIT:  conn_limit_q <= cfg_data_i;
        CFG_REGISTERING_LIMIT: reg_limit_q  <= cfg_data_i;
        CFG_STREAMING_LIMIT:   strm_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next state and result for the incoming beat
  always_comb begin
    logic [LIMIT_WIDTH-1:0] cur_lim;
    logic [LIMIT_WIDTH-1:0] tgt_lim;
    logic [LIMIT_WIDTH:0]   next_cnt;
    state_d   = state_q;
    running_d = running_q;
    armed_d   = armed_q;
    elapsed_d = elapsed_q;
    res       = '0;
    cur_lim   = limit_of(state_q, conn_limit_q, reg_limit_q, strm_limit_q);
    tgt_lim   = limit_of(target_state_i, conn_limit_q, reg_limit_q, strm_limit_q);
    next_cnt  = {1'b0, elapsed_q} + (LIMIT_WIDTH+1)'(1);

    case (kind_e'(kind_i))
      KIND_REQUEST: begin
        if (!running_q) begin
          res.not_running_reject = 1'b1;
        end else if (!is_legal(state_q, target_state_i)) begin
          res.invalid_request = 1'b1;
        end else begin
          res.accepted = 1'b1;
          if (target_state_i != state_q) begin
            state_d           = target_state_i;
            elapsed_d         = '0;
            armed_d           = (tgt_lim != '0);
            res.changed       = 1'b1;
            res.entered_pulse = 1'b1;
          end
        end
      end
      KIND_TICK: begin
        if (armed_q) begin
          if (next_cnt >= {1'b0, cur_lim}) begin
            elapsed_d         = cur_lim;
            armed_d           = 1'b0;
            res.timed_out     = 1'b1;
            res.timeout_state = state_q;
            // Error itself never arms, so entering it leaves the watchdog idle
            if (state_q != ST_DISCONNECTED && state_q != ST_ERROR && running_q &&
                is_legal(state_q, ST_ERROR)) begin
              state_d           = ST_ERROR;
              elapsed_d         = '0;
              res.changed       = 1'b1;
              res.entered_pulse = 1'b1;
            end
          end else begin
            elapsed_d = next_cnt[LIMIT_WIDTH-1:0];
          end
        end
      end
      KIND_START: begin
        if (!running_q) begin
          running_d         = 1'b1;
          state_d           = ST_DISCONNECTED;
          res.entered_pulse = 1'b1;
        end
      end
      KIND_STOP: begin
        if (running_q) begin
          armed_d   = 1'b0;
          running_d = 1'b0;
          state_d   = ST_DISCONNECTED;
        end
      end
      KIND_RESET: begin
        armed_d = 1'b0;
        if (state_q != ST_DISCONNECTED) begin
          state_d           = ST_DISCONNECTED;
          res.changed       = 1'b1;
          res.entered_pulse = 1'b1;
        end
      end
      default: ;
    endcase

    res.state_now    = state_d;
    res.state_before = state_q;
    res.running_now  = running_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_DISCONNECTED;
      running_q <= 1'b0;
      armed_q   <= 1'b0;
      elapsed_q <= '0;
    end else if (in_fire) begin
      state_q   <= state_d;
      running_q <= running_d;
      armed_q   <= armed_d;
      elapsed_q <= elapsed_d;
    end
  end

  // result register with skid stage behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o          = out_valid_q;
  assign accepted_o           = out_q.accepted;
  assign invalid_request_o    = out_q.invalid_request;
  assign not_running_reject_o = out_q.not_running_reject;
  assign state_now_o          = out_q.state_now;
  assign state_before_o       = out_q.state_before;
  assign changed_o            = out_q.changed;
  assign entered_pulse_o      = out_q.entered_pulse;
  assign timed_out_o          = out_q.timed_out;
  assign timeout_state_o      = out_q.timeout_state;
  assign running_now_o        = out_q.running_now;

  // skid entry only ever sits behind a full result register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while result register empty");

  // the watchdog only runs in a supervised state of a started session
  a_armed_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> (running_q && (state_q == ST_CONNECTING ||
                 state_q == ST_REGISTERING || state_q == ST_STREAMING)))
    else $error("watchdog armed outside a supervised state");

  // a stopped session always rests in Disconnected
  a_stopped_disc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |-> (state_q == ST_DISCONNECTED))
    else $error("stopped session not in Disconnected");

  // every taken beat leaves a result behind
  a_beat_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("event taken without a result");

  // a beat that is taken reports the state it saw
  a_before_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !out_valid_q) |=> (out_q.state_before == $past(state_q)))
    else $error("result state_before does not match prior state");

endmodule
